>>> design/key_chord_remapper_core_macros.svh
// Assertion macros shared by the key chord remapper RTL.
// Depends on a clock named clock and a synchronous reset named reset in the including module.
`ifndef KEY_CHORD_REMAPPER_CORE_MACROS_SVH
`define KEY_CHORD_REMAPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KCR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kcr assertion failed");

// Next-cycle implication, disabled while reset is high.
`define KCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kcr assertion failed");

`endif

>>> design/kcr_pkg.sv
// Types and constants for the key chord remapper.
// Used by every module of the block; depends on nothing.
package kcr_pkg;

   localparam int RSP_SLOTS = 4;
   localparam int RSP_CNT_W = $clog2(RSP_SLOTS + 1);
   localparam int RSP_IDX_W = $clog2(RSP_SLOTS);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_KEY   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_KEY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THIRD_KEY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_KEY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAS_ENABLE  = 3'd5;

   localparam logic [7:0]  RST_FIRST_KEY   = 8'd91;
   localparam logic [7:0]  RST_SECOND_KEY  = 8'd160;
   localparam logic [7:0]  RST_THIRD_KEY   = 8'd134;
   localparam logic [7:0]  RST_REPLACE_KEY = 8'd163;
   localparam logic [15:0] RST_TIMEOUT     = 16'd20;
   localparam logic        RST_SAS_ENABLE  = 1'b1;

   localparam logic [7:0] KEY_LCTRL  = 8'hA2;
   localparam logic [7:0] KEY_RCTRL  = 8'hA3;
   localparam logic [7:0] KEY_LALT   = 8'hA4;
   localparam logic [7:0] KEY_RALT   = 8'hA5;
   localparam logic [7:0] KEY_DELETE = 8'h2E;

   localparam logic ACTION_KEY  = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [1:0] KIND_INJECT  = 2'd0;
   localparam logic [1:0] KIND_VERDICT = 2'd1;
   localparam logic [1:0] KIND_TICK    = 2'd2;

   localparam logic [1:0] PRESS_IDLE   = 2'd0;
   localparam logic [1:0] PRESS_FIRST  = 2'd1;
   localparam logic [1:0] PRESS_SECOND = 2'd2;

   localparam logic [1:0] REL_IDLE       = 2'd0;
   localparam logic [1:0] REL_WAIT_FIRST  = 2'd1;
   localparam logic [1:0] REL_WAIT_SECOND = 2'd2;
   localparam logic [1:0] REL_WAIT_THIRD  = 2'd3;

   typedef struct packed {
      logic       action;
      logic [7:0] key_code;
      logic       released;
      logic       injected;
   } kcr_req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_key;
      logic       out_released;
      logic       block;
      logic       sas_request;
      logic       last;
   } kcr_rsp_type;

   typedef kcr_rsp_type [RSP_SLOTS-1:0] kcr_rsp_list_type;

   typedef struct packed {
      logic [7:0]  first_key;
      logic [7:0]  second_key;
      logic [7:0]  third_key;
      logic [7:0]  replace_key;
      logic [15:0] timeout_ticks;
      logic        sas_enable;
   } kcr_cfg_type;

   typedef struct packed {
      logic [1:0]  press_phase;
      logic [1:0]  release_phase;
      logic        first_held;
      logic        second_held;
      logic        timer_running;
      logic [15:0] timer_left;
      logic        left_ctrl_held;
      logic        right_ctrl_held;
      logic        left_alt_held;
      logic        right_alt_held;
   } kcr_state_type;

endpackage

>>> design/kcr_csr.sv
// Configuration registers of the key chord remapper.
// Depends on kcr_pkg.
module kcr_csr
   import kcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output kcr_cfg_type           cfg
);

   kcr_cfg_type cfg_ff;
   kcr_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FIRST_KEY:   cfg_in.first_key = csr_wdata[7:0];
            CSR_SECOND_KEY:  cfg_in.second_key = csr_wdata[7:0];
            CSR_THIRD_KEY:   cfg_in.third_key = csr_wdata[7:0];
            CSR_REPLACE_KEY: cfg_in.replace_key = csr_wdata[7:0];
            CSR_TIMEOUT:     cfg_in.timeout_ticks = csr_wdata[15:0];
            CSR_SAS_ENABLE:  cfg_in.sas_enable = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_key <= RST_FIRST_KEY;
         cfg_ff.second_key <= RST_SECOND_KEY;
         cfg_ff.third_key <= RST_THIRD_KEY;
         cfg_ff.replace_key <= RST_REPLACE_KEY;
         cfg_ff.timeout_ticks <= RST_TIMEOUT;
         cfg_ff.sas_enable <= RST_SAS_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/kcr_engine.sv
// Combinational chord logic: one transaction and the current state give the next state
// and the list of result transactions. Depends on kcr_pkg.
module kcr_engine
   import kcr_pkg::*;
(
   input  kcr_req_type          item,
   input  kcr_cfg_type          cfg,
   input  kcr_state_type        cur,
   output kcr_state_type        nxt,
   output kcr_rsp_list_type     results,
   output logic [RSP_CNT_W-1:0] result_cnt
);

   logic                 do_replay;
   logic                 extra_vld;
   logic [7:0]           extra_key;
   logic                 extra_rel;
   logic                 blk;
   logic                 sas;
   logic                 done;
   logic                 down;
   logic [RSP_CNT_W-1:0] n;
   kcr_rsp_type          entry;

   always_comb begin
      nxt = cur;
      do_replay = 1'b0;
      extra_vld = 1'b0;
      extra_key = '0;
      extra_rel = 1'b0;
      blk = 1'b0;
      sas = 1'b0;
      done = 1'b0;
      down = !item.released;

      if (item.action == ACTION_TICK) begin
         if (cur.timer_running) begin
            if (cur.timer_left[15:1] == '0) begin
               do_replay = 1'b1;
               nxt.timer_running = 1'b0;
               nxt.timer_left = '0;
               nxt.first_held = 1'b0;
               nxt.second_held = 1'b0;
            end else begin
               nxt.timer_left = cur.timer_left - 16'd1;
            end
         end
      end else begin
         if (!item.injected) begin
            if (down) begin
               if (item.key_code == cfg.first_key) begin
                  do_replay = 1'b1;
                  nxt.first_held = 1'b1;
                  nxt.second_held = 1'b0;
                  nxt.press_phase = PRESS_FIRST;
                  nxt.timer_running = 1'b1;
                  nxt.timer_left = cfg.timeout_ticks;
                  blk = 1'b1;
               end else if (cur.press_phase == PRESS_FIRST) begin
                  if (item.key_code == cfg.second_key) begin
                     nxt.second_held = 1'b1;
                     nxt.press_phase = PRESS_SECOND;
                     blk = 1'b1;
                  end else begin
                     do_replay = 1'b1;
                  end
               end else if (cur.press_phase == PRESS_SECOND) begin
                  if (item.key_code == cfg.third_key) begin
                     nxt.release_phase = REL_WAIT_THIRD;
                     extra_vld = !cur.right_ctrl_held;
                     extra_key = cfg.replace_key;
                     nxt.press_phase = PRESS_IDLE;
                     nxt.timer_running = 1'b0;
                     nxt.timer_left = '0;
                     nxt.first_held = 1'b0;
                     nxt.second_held = 1'b0;
                     blk = 1'b1;
                  end else begin
                     do_replay = 1'b1;
                  end
               end
               if (do_replay && item.key_code != cfg.first_key) begin
                  nxt.press_phase = PRESS_IDLE;
                  nxt.first_held = 1'b0;
                  nxt.second_held = 1'b0;
                  nxt.timer_running = 1'b0;
                  nxt.timer_left = '0;
               end
            end else begin
               if (cur.press_phase != PRESS_IDLE) begin
                  do_replay = 1'b1;
                  nxt.press_phase = PRESS_IDLE;
                  nxt.first_held = 1'b0;
                  nxt.second_held = 1'b0;
                  nxt.timer_running = 1'b0;
                  nxt.timer_left = '0;
                  if (cur.first_held && item.key_code == cfg.first_key) begin
                     extra_vld = 1'b1;
                     extra_key = cfg.first_key;
                     extra_rel = 1'b1;
                     blk = 1'b1;
                     done = 1'b1;
                  end else if (cur.second_held && item.key_code == cfg.second_key) begin
                     extra_vld = 1'b1;
                     extra_key = cfg.second_key;
                     extra_rel = 1'b1;
                     blk = 1'b1;
                     done = 1'b1;
                  end
               end
               if (!done) begin
                  if (item.key_code == cfg.third_key &&
                      cur.release_phase == REL_WAIT_THIRD) begin
                     nxt.release_phase = REL_WAIT_SECOND;
                     extra_vld = 1'b1;
                     extra_key = cfg.replace_key;
                     extra_rel = 1'b1;
                     blk = 1'b1;
                  end else if (item.key_code == cfg.second_key &&
                               cur.release_phase == REL_WAIT_SECOND) begin
                     nxt.release_phase = REL_WAIT_FIRST;
                     blk = 1'b1;
                  end else if (item.key_code == cfg.first_key &&
                               cur.release_phase == REL_WAIT_FIRST) begin
                     nxt.release_phase = REL_IDLE;
                     blk = 1'b1;
                  end
               end
            end
         end
         if (!blk) begin
            if (item.key_code == KEY_LALT) begin
               nxt.left_alt_held = down;
            end
            if (item.key_code == KEY_RALT) begin
               nxt.right_alt_held = down;
            end
            if (item.key_code == KEY_LCTRL) begin
               nxt.left_ctrl_held = down;
            end
            if (item.key_code == KEY_RCTRL) begin
               nxt.right_ctrl_held = down;
            end
            sas = down && item.key_code == KEY_DELETE &&
                  (nxt.left_alt_held || nxt.right_alt_held) &&
                  (nxt.left_ctrl_held || nxt.right_ctrl_held) && cfg.sas_enable;
         end
      end
   end

   always_comb begin
      results = '0;
      n = '0;
      entry = '0;
      if (do_replay && cur.first_held) begin
         entry = '0;
         entry.kind = KIND_INJECT;
         entry.out_key = cfg.first_key;
         results[n[RSP_IDX_W-1:0]] = entry;
         n = n + 1'b1;
      end
      if (do_replay && cur.second_held) begin
         entry = '0;
         entry.kind = KIND_INJECT;
         entry.out_key = cfg.second_key;
         results[n[RSP_IDX_W-1:0]] = entry;
         n = n + 1'b1;
      end
      if (extra_vld) begin
         entry = '0;
         entry.kind = KIND_INJECT;
         entry.out_key = extra_key;
         entry.out_released = extra_rel;
         results[n[RSP_IDX_W-1:0]] = entry;
         n = n + 1'b1;
      end
      entry = '0;
      entry.kind = (item.action == ACTION_TICK) ? KIND_TICK : KIND_VERDICT;
      entry.block = blk;
      entry.sas_request = sas;
      entry.last = 1'b1;
      results[n[RSP_IDX_W-1:0]] = entry;
      result_cnt = n + 1'b1;
   end

endmodule

>>> design/kcr_rsp_queue.sv
// Result queue: holds the result transactions of one input and hands them out one a cycle while rsp_stall is low.
// Depends on kcr_pkg.
module kcr_rsp_queue
   import kcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  kcr_rsp_list_type     load_items,
   input  logic [RSP_CNT_W-1:0] load_cnt,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output kcr_rsp_type          rsp_payload
);

   kcr_rsp_list_type     slot_ff;
   kcr_rsp_list_type     slot_in;
   logic [RSP_CNT_W-1:0] cnt_ff;
   logic [RSP_CNT_W-1:0] cnt_in;
   logic                 take;

   assign rsp_valid = cnt_ff != '0;
   assign rsp_payload = slot_ff[0];
   assign take = rsp_valid && !rsp_stall;
   assign free = (cnt_ff == '0) || (cnt_ff == RSP_CNT_W'(1) && take);

   always_comb begin
      slot_in = slot_ff;
      cnt_in = cnt_ff;
      if (load) begin
         slot_in = load_items;
         cnt_in = load_cnt;
      end else if (take) begin
         for (int i = 0; i < RSP_SLOTS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> design/key_chord_remapper_core.sv
// Top level of the key chord remapper: input register, chord state, engine and result queue.
// Depends on kcr_pkg, kcr_csr, kcr_engine, kcr_rsp_queue and the assertion macro header.
//
// Each input transaction is taken into an input register and, once the result queue is
// empty or handing out its last entry, evaluated by the combinational engine, which updates the chord
// state and loads between one and four result transactions into the queue. The queue hands
// out one result per cycle while rsp_stall is low, so an input holds the queue until its
// results are out: one for most ticks and key events, up to three when a tick or a key
// replays the held keys, and four when held keys are replayed ahead of an injected
// release. The input register takes the next transaction while results still drain, and
// the drain rate of the result queue sets the sustained pace.
`include "key_chord_remapper_core_macros.svh"

module key_chord_remapper_core
   import kcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kcr_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kcr_rsp_type           rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   kcr_cfg_type          cfg;
   kcr_req_type          item_ff;
   logic                 item_vld_ff;
   logic                 item_vld_in;
   kcr_state_type        state_ff;
   kcr_state_type        state_nxt;
   kcr_rsp_list_type     results;
   logic [RSP_CNT_W-1:0] result_cnt;
   logic                 queue_free;
   logic                 process;
   logic                 req_take;

   assign process = item_vld_ff && queue_free;
   assign req_stall = item_vld_ff && !queue_free;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      item_vld_in = item_vld_ff;
      if (req_take) begin
         item_vld_in = 1'b1;
      end else if (process) begin
         item_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_payload;
      end
      if (reset) begin
         item_vld_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         if (process) begin
            state_ff <= state_nxt;
         end
      end
   end

   kcr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kcr_engine u_engine (
      .item       (item_ff),
      .cfg        (cfg),
      .cur        (state_ff),
      .nxt        (state_nxt),
      .results    (results),
      .result_cnt (result_cnt)
   );

   kcr_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .load        (process),
      .load_items  (results),
      .load_cnt    (result_cnt),
      .free        (queue_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `KCR_ASSERT_NEXT(a_process_fills_queue, process, rsp_valid)
   `KCR_ASSERT_IMPL(a_stall_needs_item, req_stall, item_vld_ff)
   `KCR_ASSERT_IMPL(a_held_needs_phase, state_ff.first_held || state_ff.second_held,
                    state_ff.press_phase != PRESS_IDLE)
   `KCR_ASSERT_IMPL(a_second_held_phase, state_ff.second_held, state_ff.press_phase == PRESS_SECOND)

endmodule

>>> bench/kcr_remap_checker.sv
// Response checker for the key chord remapper: tracks register writes, predicts the
// response transactions of every request and compares them as they leave the block.
// Depends on kcr_pkg for the payload, register and code definitions.
module kcr_remap_checker
   import kcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  kcr_req_type           req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  kcr_rsp_type           rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    outstanding,
   output int                    checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   kcr_cfg_type   cfg;
   kcr_state_type chord;
   kcr_rsp_type   expected_rsp[$];
   int            errors = 0;
   int            compared = 0;

   task queue_result(input logic [1:0] kind, input logic [7:0] key, input logic rel,
                     input logic blk, input logic sas, input logic last);
      kcr_rsp_type r;
      r.kind = kind;
      r.out_key = key;
      r.out_released = rel;
      r.block = blk;
      r.sas_request = sas;
      r.last = last;
      expected_rsp.push_back(r);
   endtask

   task replay_held();
      if (chord.first_held) begin
         chord.first_held = 1'b0;
         queue_result(KIND_INJECT, cfg.first_key, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      if (chord.second_held) begin
         chord.second_held = 1'b0;
         queue_result(KIND_INJECT, cfg.second_key, 1'b0, 1'b0, 1'b0, 1'b0);
      end
   endtask

   task stop_timer_replay();
      replay_held();
      chord.timer_running = 1'b0;
      chord.timer_left = '0;
   endtask

   always @(posedge clock) begin
      kcr_req_type req;
      kcr_rsp_type want;
      kcr_rsp_type got;
      logic        blk;
      logic        sas;
      logic        down;
      logic        had_first;
      logic        had_second;
      if (reset) begin
         cfg.first_key = RST_FIRST_KEY;
         cfg.second_key = RST_SECOND_KEY;
         cfg.third_key = RST_THIRD_KEY;
         cfg.replace_key = RST_REPLACE_KEY;
         cfg.timeout_ticks = RST_TIMEOUT;
         cfg.sas_enable = RST_SAS_ENABLE;
         chord = '0;
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_KEY:   cfg.first_key = csr_wdata[7:0];
               CSR_SECOND_KEY:  cfg.second_key = csr_wdata[7:0];
               CSR_THIRD_KEY:   cfg.third_key = csr_wdata[7:0];
               CSR_REPLACE_KEY: cfg.replace_key = csr_wdata[7:0];
               CSR_TIMEOUT:     cfg.timeout_ticks = csr_wdata[15:0];
               CSR_SAS_ENABLE:  cfg.sas_enable = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            req = req_payload;
            if (req.action == ACTION_TICK) begin
               if (chord.timer_running) begin
                  if (chord.timer_left <= 16'd1) begin
                     chord.timer_running = 1'b0;
                     chord.timer_left = '0;
                     replay_held();
                  end else begin
                     chord.timer_left = chord.timer_left - 16'd1;
                  end
               end
               queue_result(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
               blk = 1'b0;
               sas = 1'b0;
               if (!req.injected && !req.released) begin
                  if (req.key_code == cfg.first_key) begin
                     stop_timer_replay();
                     chord.first_held = 1'b1;
                     chord.press_phase = PRESS_FIRST;
                     chord.timer_running = 1'b1;
                     chord.timer_left = cfg.timeout_ticks;
                     blk = 1'b1;
                  end else if (chord.press_phase == PRESS_FIRST) begin
                     if (req.key_code == cfg.second_key) begin
                        chord.second_held = 1'b1;
                        chord.press_phase = PRESS_SECOND;
                        blk = 1'b1;
                     end else begin
                        stop_timer_replay();
                        chord.press_phase = PRESS_IDLE;
                     end
                  end else if (chord.press_phase == PRESS_SECOND) begin
                     if (req.key_code == cfg.third_key) begin
                        chord.press_phase = PRESS_IDLE;
                        chord.release_phase = REL_WAIT_THIRD;
                        chord.timer_running = 1'b0;
                        chord.timer_left = '0;
                        chord.first_held = 1'b0;
                        chord.second_held = 1'b0;
                        if (!chord.right_ctrl_held)
                           queue_result(KIND_INJECT, cfg.replace_key, 1'b0, 1'b0, 1'b0, 1'b0);
                        blk = 1'b1;
                     end else begin
                        stop_timer_replay();
                        chord.press_phase = PRESS_IDLE;
                     end
                  end
               end else if (!req.injected) begin
                  if (chord.press_phase != PRESS_IDLE) begin
                     had_first = chord.first_held;
                     had_second = chord.second_held;
                     stop_timer_replay();
                     chord.press_phase = PRESS_IDLE;
                     if (had_first && req.key_code == cfg.first_key) begin
                        queue_result(KIND_INJECT, cfg.first_key, 1'b1, 1'b0, 1'b0, 1'b0);
                        blk = 1'b1;
                     end else if (had_second && req.key_code == cfg.second_key) begin
                        queue_result(KIND_INJECT, cfg.second_key, 1'b1, 1'b0, 1'b0, 1'b0);
                        blk = 1'b1;
                     end
                  end
                  if (!blk) begin
                     if (req.key_code == cfg.third_key &&
                         chord.release_phase == REL_WAIT_THIRD) begin
                        chord.release_phase = REL_WAIT_SECOND;
                        queue_result(KIND_INJECT, cfg.replace_key, 1'b1, 1'b0, 1'b0, 1'b0);
                        blk = 1'b1;
                     end else if (req.key_code == cfg.second_key &&
                                  chord.release_phase == REL_WAIT_SECOND) begin
                        chord.release_phase = REL_WAIT_FIRST;
                        blk = 1'b1;
                     end else if (req.key_code == cfg.first_key &&
                                  chord.release_phase == REL_WAIT_FIRST) begin
                        chord.release_phase = REL_IDLE;
                        blk = 1'b1;
                     end
                  end
               end
               if (!blk) begin
                  down = !req.released;
                  if (req.key_code == KEY_LALT) chord.left_alt_held = down;
                  if (req.key_code == KEY_RALT) chord.right_alt_held = down;
                  if (req.key_code == KEY_LCTRL) chord.left_ctrl_held = down;
                  if (req.key_code == KEY_RCTRL) chord.right_ctrl_held = down;
                  sas = down && req.key_code == KEY_DELETE &&
                        (chord.left_alt_held || chord.right_alt_held) &&
                        (chord.left_ctrl_held || chord.right_ctrl_held) && cfg.sas_enable;
               end
               queue_result(KIND_VERDICT, 8'h00, 1'b0, blk, sas, 1'b1);
            end
         end

         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_rsp.size() == 0) begin
               $error("response transaction %h arrived with none expected", got);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               compared++;
               if (got.kind !== want.kind) begin
                  $error("kind expected %0d actual %0d", want.kind, got.kind);
                  errors++;
               end
               if (got.out_key !== want.out_key) begin
                  $error("out_key expected %h actual %h", want.out_key, got.out_key);
                  errors++;
               end
               if (got.out_released !== want.out_released) begin
                  $error("out_released expected %b actual %b", want.out_released,
                         got.out_released);
                  errors++;
               end
               if (got.block !== want.block) begin
                  $error("block expected %b actual %b", want.block, got.block);
                  errors++;
               end
               if (got.sas_request !== want.sas_request) begin
                  $error("sas_request expected %b actual %b", want.sas_request,
                         got.sas_request);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("last expected %b actual %b", want.last, got.last);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      outstanding <= expected_rsp.size();
      checked_count <= compared;
   end

endmodule

>>> bench/tb_key_chord_remapper_core.sv
// Top of the key chord remapper testbench: clock, reset, request and register stimulus,
// response back-pressure and the final verdict.
// Depends on kcr_pkg, key_chord_remapper_core and kcr_remap_checker.
module tb_key_chord_remapper_core
   import kcr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   kcr_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   kcr_rsp_type           rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int          mismatch_count;
   int          outstanding;
   int          checked_count;
   kcr_cfg_type cur_cfg;
   int          items_sent = 0;
   int          burst_left = 0;
   int          drain_failures = 0;
   int          settings = 0;
   int          stall_mode = 0;
   int          stall_left = 0;

   key_chord_remapper_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   kcr_remap_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic kcr_req_type key_item(input logic [7:0] code, input logic rel,
                                            input logic inj);
      kcr_req_type item;
      item.action = ACTION_KEY;
      item.key_code = code;
      item.released = rel;
      item.injected = inj;
      return item;
   endfunction

   function automatic kcr_req_type tick_item();
      kcr_req_type item;
      item = '0;
      item.action = ACTION_TICK;
      item.key_code = 8'($urandom_range(0, 255));
      item.released = 1'($urandom);
      item.injected = 1'($urandom);
      return item;
   endfunction

   task automatic send_item(input kcr_req_type item);
      int gap;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_cfg(input kcr_cfg_type c);
      csr_put(CSR_FIRST_KEY, {8'h00, c.first_key});
      csr_put(CSR_SECOND_KEY, {8'h00, c.second_key});
      csr_put(CSR_THIRD_KEY, {8'h00, c.third_key});
      csr_put(CSR_REPLACE_KEY, {8'h00, c.replace_key});
      csr_put(CSR_TIMEOUT, c.timeout_ticks);
      csr_put(CSR_SAS_ENABLE, {15'h0000, c.sas_enable});
      csr_valid <= 1'b0;
      cur_cfg = c;
      settings++;
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (outstanding != 0) begin
         $error("%0d response transactions never arrived", outstanding);
         drain_failures++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic run_episode();
      int         pick;
      int         n;
      logic [7:0] ctrl_key;
      logic [7:0] alt_key;
      logic [7:0] trio [3];
      trio[0] = cur_cfg.first_key;
      trio[1] = cur_cfg.second_key;
      trio[2] = cur_cfg.third_key;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_item(key_item(cur_cfg.first_key, 1'b0, 1'b0));
         if ($urandom_range(0, 3) == 0) send_item(tick_item());
         send_item(key_item(cur_cfg.second_key, 1'b0, 1'b0));
         if ($urandom_range(0, 4) == 0)
            send_item(key_item(8'($urandom_range(0, 255)), 1'($urandom), 1'b1));
         send_item(key_item(cur_cfg.third_key, 1'b0, 1'b0));
         if ($urandom_range(0, 3) == 0) begin
            repeat (3) send_item(key_item(trio[$urandom_range(0, 2)], 1'b1, 1'b0));
         end else begin
            send_item(key_item(cur_cfg.third_key, 1'b1, 1'b0));
            if ($urandom_range(0, 4) == 0) send_item(tick_item());
            send_item(key_item(cur_cfg.second_key, 1'b1, 1'b0));
            send_item(key_item(cur_cfg.first_key, 1'b1, 1'b0));
         end
      end else if (pick < 60) begin
         send_item(key_item(cur_cfg.first_key, 1'b0, 1'b0));
         if ($urandom_range(0, 1) == 0) send_item(key_item(cur_cfg.second_key, 1'b0, 1'b0));
         case ($urandom_range(0, 3))
            0: send_item(key_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            1: send_item(key_item(cur_cfg.first_key, 1'b1, 1'b0));
            2: send_item(key_item(cur_cfg.second_key, 1'b1, 1'b0));
            default: begin
               n = (cur_cfg.timeout_ticks >= 16'd12) ? $urandom_range(1, 12)
                                                      : int'(cur_cfg.timeout_ticks) + 1;
               repeat (n) send_item(tick_item());
            end
         endcase
      end else if (pick < 75) begin
         ctrl_key = ($urandom_range(0, 1) == 0) ? KEY_LCTRL : KEY_RCTRL;
         alt_key = ($urandom_range(0, 1) == 0) ? KEY_LALT : KEY_RALT;
         send_item(key_item(ctrl_key, 1'b0, $urandom_range(0, 3) == 0));
         send_item(key_item(alt_key, 1'b0, $urandom_range(0, 3) == 0));
         if ($urandom_range(0, 2) == 0) begin
            send_item(key_item(cur_cfg.first_key, 1'b0, 1'b0));
            send_item(key_item(cur_cfg.second_key, 1'b0, 1'b0));
            send_item(key_item(cur_cfg.third_key, 1'b0, 1'b0));
         end
         send_item(key_item(KEY_DELETE, 1'b0, $urandom_range(0, 3) == 0));
         send_item(key_item(KEY_DELETE, 1'b1, 1'b0));
         if ($urandom_range(0, 3) != 0) begin
            send_item(key_item(alt_key, 1'b1, $urandom_range(0, 3) == 0));
            send_item(key_item(ctrl_key, 1'b1, $urandom_range(0, 3) == 0));
         end
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 8)) send_item(tick_item());
      end else begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 4) == 0) send_item(tick_item());
            else send_item(key_item(8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom)));
         end
      end
   endtask

   initial begin
      kcr_cfg_type c;
      int          target;
      cur_cfg.first_key = RST_FIRST_KEY;
      cur_cfg.second_key = RST_SECOND_KEY;
      cur_cfg.third_key = RST_THIRD_KEY;
      cur_cfg.replace_key = RST_REPLACE_KEY;
      cur_cfg.timeout_ticks = RST_TIMEOUT;
      cur_cfg.sas_enable = RST_SAS_ENABLE;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Full chord with release, early releases of held keys, and a broken chord.
      send_item(key_item(RST_FIRST_KEY, 1'b0, 1'b0));
      send_item(key_item(RST_SECOND_KEY, 1'b0, 1'b0));
      send_item(key_item(RST_THIRD_KEY, 1'b0, 1'b0));
      send_item(key_item(RST_THIRD_KEY, 1'b1, 1'b0));
      send_item(key_item(RST_SECOND_KEY, 1'b1, 1'b0));
      send_item(key_item(RST_FIRST_KEY, 1'b1, 1'b0));
      send_item(key_item(RST_FIRST_KEY, 1'b0, 1'b0));
      send_item(key_item(RST_FIRST_KEY, 1'b1, 1'b0));
      send_item(key_item(RST_FIRST_KEY, 1'b0, 1'b0));
      send_item(key_item(RST_SECOND_KEY, 1'b0, 1'b0));
      send_item(key_item(RST_SECOND_KEY, 1'b1, 1'b0));
      send_item(key_item(RST_FIRST_KEY, 1'b0, 1'b0));
      send_item(key_item(8'h00, 1'b0, 1'b0));
      send_item(key_item(8'hFF, 1'b1, 1'b1));
      // Secure attention with modifiers held, then a chord while right Ctrl is down.
      send_item(key_item(KEY_RCTRL, 1'b0, 1'b0));
      send_item(key_item(KEY_LALT, 1'b0, 1'b0));
      send_item(key_item(KEY_DELETE, 1'b0, 1'b0));
      send_item(key_item(RST_FIRST_KEY, 1'b0, 1'b0));
      send_item(key_item(RST_SECOND_KEY, 1'b0, 1'b0));
      send_item(key_item(RST_THIRD_KEY, 1'b0, 1'b0));
      send_item(key_item(KEY_RCTRL, 1'b1, 1'b0));
      send_item(key_item(KEY_LALT, 1'b1, 1'b0));
      wait_drained();

      // Timer restart on a repeated first key, expiry, and a tick with no timer running.
      c = cur_cfg;
      c.timeout_ticks = 16'd2;
      program_cfg(c);
      send_item(key_item(cur_cfg.first_key, 1'b0, 1'b0));
      send_item(tick_item());
      send_item(key_item(cur_cfg.first_key, 1'b0, 1'b0));
      repeat (3) send_item(tick_item());
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: c = '{8'h00, 8'hFF, 8'h80, 8'hFF, 16'h0000, 1'b1};
            1: c = '{8'hFF, 8'h00, 8'h7F, 8'h00, 16'hFFFF, 1'b0};
            2: c = '{8'h5A, 8'h5A, 8'h5A, 8'hA5, 16'h0001, 1'b1};
            default: begin
               c.first_key = 8'($urandom_range(0, 255));
               c.second_key = 8'($urandom_range(0, 255));
               c.third_key = 8'($urandom_range(0, 255));
               c.replace_key = 8'($urandom_range(0, 255));
               c.timeout_ticks = 16'($urandom_range(1, 6));
               c.sas_enable = 1'($urandom);
            end
         endcase
         program_cfg(c);
         target = items_sent + 75;
         while (items_sent < target) run_episode();
         wait_drained();
      end

      $display("Sent %0d requests: chords, held-key replays, timer expiry, modifier tracking",
               items_sent);
      $display("and random traffic over %0d register settings; %0d responses compared.",
               settings + 1, checked_count);
      if (mismatch_count == 0 && drain_failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
